// ----- src/yiqpo_pkg.sv -----
package yiqpo_pkg;

    typedef struct packed {
        logic [7:0]         chan0_in;
        logic [7:0]         chan1_in;
        logic [7:0]         chan2_in;
        logic signed [15:0] pulse_y;
        logic signed [15:0] pulse_i;
        logic signed [15:0] pulse_q;
        logic               end_of_frame;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] chan0_out;
        logic [7:0] chan1_out;
        logic [7:0] chan2_out;
        logic       frame_last;
    } pix_out_t;

    localparam int ONE_Q14 = 16384;
    localparam int DIV_BITS = 15;

    // NTSC forward and inverse matrices, Q2.14, row major
    localparam logic signed [15:0] TO_YIQ [9] = '{
        16'sd4899,  16'sd9617,  16'sd1868,
        16'sd9765, -16'sd4489, -16'sd5276,
        16'sd3457, -16'sd8569,  16'sd5112
    };

    localparam logic signed [15:0] TO_RGB [9] = '{
        16'sd16384,  16'sd15663,  16'sd10174,
        16'sd16384, -16'sd4456,  -16'sd10600,
        16'sd16384, -16'sd18121,  16'sd27902
    };

    function automatic logic signed [17:0] sat18(input logic signed [35:0] v);
        logic signed [17:0] r;
        if (v > 36'sd131071)
            r = 18'sd131071;
        else if (v < -36'sd131072)
            r = -18'sd131072;
        else
            r = v[17:0];
        return r;
    endfunction

    // floor((s + 8192) / 16384), then saturate to Q3.14
    function automatic logic signed [17:0] round_sat(input logic signed [35:0] s);
        logic signed [35:0] w;
        w = (s + 36'sd8192) >>> 14;
        return sat18(w);
    endfunction

endpackage

// ----- src/yiq_pulse_overlay_pixel.sv -----
// Pixel pulse overlay: each pixel is scaled to Q3.14, taken to YIQ, the
// signed Q3.12 pulse is added, and it is taken back to RGB. When the largest
// channel exceeds one, all channels are divided by it, then each is clamped
// to 0..1 and truncated to 8 bits. One pixel per clock is accepted while
// no result is stalled at the output, and one result is delivered per pixel,
// in order. Between acceptance and dst_valid lie the input register, five
// arithmetic stages for scaling and the two matrix products, one stage that
// picks the divisor, fifteen stages of a one-bit-per-stage restoring divider
// for the normalization, and the output register. The whole pipeline holds
// while a result is stalled at the output.
module yiq_pulse_overlay_pixel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  yiqpo_pkg::pix_in_t src_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output yiqpo_pkg::pix_out_t dst_data
);

    localparam int NDIV = yiqpo_pkg::DIV_BITS;

    logic adv;

    // stage 1: input register
    logic               s1_valid_reg;
    logic [7:0]         s1_c_reg [3];
    logic signed [15:0] s1_p_reg [3];
    logic               s1_eof_reg;

    // stage 2: scaled pixel
    logic               s2_valid_reg;
    logic [14:0]        s2_x_reg [3];
    logic [14:0]        s2_x_next [3];
    logic signed [15:0] s2_p_reg [3];
    logic               s2_eof_reg;

    // stage 3: forward products
    logic               s3_valid_reg;
    logic signed [31:0] s3_prod_reg [9];
    logic signed [31:0] s3_prod_next [9];
    logic signed [15:0] s3_p_reg [3];
    logic               s3_eof_reg;

    // stage 4: YIQ plus pulse
    logic               s4_valid_reg;
    logic signed [17:0] s4_yiq_reg [3];
    logic signed [17:0] s4_yiq_next [3];
    logic               s4_eof_reg;

    // stage 5: inverse products
    logic               s5_valid_reg;
    logic signed [33:0] s5_prod_reg [9];
    logic signed [33:0] s5_prod_next [9];
    logic               s5_eof_reg;

    // stage 6: RGB
    logic               s6_valid_reg;
    logic signed [17:0] s6_rgb_reg [3];
    logic signed [17:0] s6_rgb_next [3];
    logic               s6_eof_reg;

    // divider pipeline, index 0 holds dividend and divisor
    logic               dv_valid_reg [NDIV+1];
    logic [17:0]        dv_r_reg [NDIV+1][3];
    logic [14:0]        dv_q_reg [NDIV+1][3];
    logic [16:0]        dv_m_reg [NDIV+1];
    logic               dv_eof_reg [NDIV+1];
    logic [17:0]        dv_r_next [1:NDIV][3];
    logic [14:0]        dv_q_next [1:NDIV][3];

    logic [16:0]        dv0_m_next;
    logic [17:0]        dv0_r_next [3];

    logic               out_valid_reg;
    yiqpo_pkg::pix_out_t out_data_reg;
    yiqpo_pkg::pix_out_t out_data_next;

    assign adv       = !(out_valid_reg && dst_stall);
    assign src_stall = !adv;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= NDIV; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= src_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            s6_valid_reg    <= s5_valid_reg;
            dv_valid_reg[0] <= s6_valid_reg;
            for (int i = 1; i <= NDIV; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            out_valid_reg <= dv_valid_reg[NDIV];
        end
    end

    // scale c/255 to Q3.14: 64c + floor((64c + 127) / 255)
    always_comb
    begin
        logic [14:0] a;
        logic [31:0] t;
        for (int k = 0; k < 3; k++)
        begin
            a = {1'b0, s1_c_reg[k], 6'd0} + 15'd127;
            t = (32'(a) + 32'd1) * 32'd257;
            s2_x_next[k] = {1'b0, s1_c_reg[k], 6'd0} + 15'(t[31:16]);
        end
    end

    always_comb
    begin
        logic signed [15:0] xs;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                xs = signed'({1'b0, s2_x_reg[k]});
                s3_prod_next[3*r+k] = xs * yiqpo_pkg::TO_YIQ[3*r+k];
            end
        end
    end

    always_comb
    begin
        logic signed [35:0] sum;
        logic signed [17:0] y;
        logic signed [35:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            sum = 36'(s3_prod_reg[3*r]) + 36'(s3_prod_reg[3*r+1])
                + 36'(s3_prod_reg[3*r+2]);
            y   = yiqpo_pkg::round_sat(sum);
            acc = 36'(y) + (36'(s3_p_reg[r]) <<< 2);
            s4_yiq_next[r] = yiqpo_pkg::sat18(acc);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s5_prod_next[3*r+k] = s4_yiq_reg[k] * yiqpo_pkg::TO_RGB[3*r+k];
            end
        end
    end

    always_comb
    begin
        logic signed [35:0] sum;
        for (int r = 0; r < 3; r++)
        begin
            sum = 36'(s5_prod_reg[3*r]) + 36'(s5_prod_reg[3*r+1])
                + 36'(s5_prod_reg[3*r+2]);
            s6_rgb_next[r] = yiqpo_pkg::round_sat(sum);
        end
    end

    // without normalization, divide by one: quotient equals the channel
    always_comb
    begin
        logic signed [17:0] m;
        m = s6_rgb_reg[0];
        if (s6_rgb_reg[1] > m)
            m = s6_rgb_reg[1];
        if (s6_rgb_reg[2] > m)
            m = s6_rgb_reg[2];
        if (m > 18'(yiqpo_pkg::ONE_Q14))
            dv0_m_next = m[16:0];
        else
            dv0_m_next = 17'(yiqpo_pkg::ONE_Q14);
        for (int k = 0; k < 3; k++)
        begin
            if (s6_rgb_reg[k] < 18'sd0)
                dv0_r_next[k] = '0;
            else
                dv0_r_next[k] = s6_rgb_reg[k];
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    always_comb
    begin
        logic [17:0] sh;
        for (int g = 1; g <= NDIV; g++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (g == 1)
                    sh = dv_r_reg[g-1][k];
                else
                    sh = {dv_r_reg[g-1][k][16:0], 1'b0};
                dv_q_next[g][k] = dv_q_reg[g-1][k];
                if (sh >= {1'b0, dv_m_reg[g-1]})
                begin
                    dv_r_next[g][k] = sh - {1'b0, dv_m_reg[g-1]};
                    dv_q_next[g][k][NDIV-g] = 1'b1;
                end
                else
                begin
                    dv_r_next[g][k] = sh;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_c_reg[0] <= src_data.chan0_in;
            s1_c_reg[1] <= src_data.chan1_in;
            s1_c_reg[2] <= src_data.chan2_in;
            s1_p_reg[0] <= src_data.pulse_y;
            s1_p_reg[1] <= src_data.pulse_i;
            s1_p_reg[2] <= src_data.pulse_q;
            s1_eof_reg  <= src_data.end_of_frame;

            s2_x_reg   <= s2_x_next;
            s2_p_reg   <= s1_p_reg;
            s2_eof_reg <= s1_eof_reg;

            s3_prod_reg <= s3_prod_next;
            s3_p_reg    <= s2_p_reg;
            s3_eof_reg  <= s2_eof_reg;

            s4_yiq_reg <= s4_yiq_next;
            s4_eof_reg <= s3_eof_reg;

            s5_prod_reg <= s5_prod_next;
            s5_eof_reg  <= s4_eof_reg;

            s6_rgb_reg <= s6_rgb_next;
            s6_eof_reg <= s5_eof_reg;

            dv_m_reg[0]   <= dv0_m_next;
            dv_eof_reg[0] <= s6_eof_reg;
            for (int k = 0; k < 3; k++)
            begin
                dv_r_reg[0][k] <= dv0_r_next[k];
                dv_q_reg[0][k] <= '0;
            end
            for (int i = 1; i <= NDIV; i++)
            begin
                dv_m_reg[i]   <= dv_m_reg[i-1];
                dv_eof_reg[i] <= dv_eof_reg[i-1];
                dv_r_reg[i]   <= dv_r_next[i];
                dv_q_reg[i]   <= dv_q_next[i];
            end

            out_data_reg <= out_data_next;
        end
    end

    // quotient never exceeds one; result is floor(v * 255 / 16384)
    always_comb
    begin
        logic [22:0] p [3];
        for (int k = 0; k < 3; k++)
        begin
            p[k] = {dv_q_reg[NDIV][k], 8'd0} - 23'(dv_q_reg[NDIV][k]);
        end
        out_data_next.chan0_out  = p[0][21:14];
        out_data_next.chan1_out  = p[1][21:14];
        out_data_next.chan2_out  = p[2][21:14];
        out_data_next.frame_last = dv_eof_reg[NDIV];
    end

endmodule

// ----- verif/yiq_pulse_overlay_pixel_tb.sv -----
`timescale 1ns / 1ps

module yiq_pulse_overlay_pixel_tb;

    localparam int LATENCY = 23;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    yiqpo_pkg::pix_in_t  src_data;
    logic                dst_valid;
    logic                dst_stall;
    yiqpo_pkg::pix_out_t dst_data;

    yiq_pulse_overlay_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    typedef struct {
        yiqpo_pkg::pix_in_t  pix;
        logic                known;
        yiqpo_pkg::pix_out_t want;
    } stim_row_t;

    yiqpo_pkg::pix_out_t pixel_queue[$];
    int       error_count;
    int       checked_count;
    int       sent_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    logic     hold_off;
    int       cycle_count;

    // NTSC matrices, Q2.14
    const int fwd_mtx[9] = '{4899, 9617, 1868, 9765, -4489, -5276, 3457, -8569, 5112};
    const int inv_mtx[9] = '{16384, 15663, 10174, 16384, -4456, -10600,
                             16384, -18121, 27902};

    function automatic longint clip_q314(longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic yiqpo_pkg::pix_out_t overlay_pixel(yiqpo_pkg::pix_in_t p);
        longint   lin[3];
        longint   yiq[3];
        longint   res[3];
        longint   pulse[3];
        longint   s;
        longint   mx;
        longint   v;
        yiqpo_pkg::pix_out_t o;
        lin[0] = (longint'(p.chan0_in) * 16384 + 127) / 255;
        lin[1] = (longint'(p.chan1_in) * 16384 + 127) / 255;
        lin[2] = (longint'(p.chan2_in) * 16384 + 127) / 255;
        pulse[0] = p.pulse_y;
        pulse[1] = p.pulse_i;
        pulse[2] = p.pulse_q;
        for (int k = 0; k < 3; k++)
        begin
            s = lin[0] * fwd_mtx[3*k] + lin[1] * fwd_mtx[3*k+1] + lin[2] * fwd_mtx[3*k+2];
            yiq[k] = clip_q314(clip_q314(floor_div(s + 8192, 16384)) + pulse[k] * 4);
        end
        for (int k = 0; k < 3; k++)
        begin
            s = yiq[0] * inv_mtx[3*k] + yiq[1] * inv_mtx[3*k+1] + yiq[2] * inv_mtx[3*k+2];
            res[k] = clip_q314(floor_div(s + 8192, 16384));
        end
        mx = res[0];
        if (res[1] > mx)
            mx = res[1];
        if (res[2] > mx)
            mx = res[2];
        if (mx > 16384)
        begin
            for (int k = 0; k < 3; k++)
                res[k] = (res[k] <= 0) ? 0 : (res[k] * 16384) / mx;
        end
        for (int k = 0; k < 3; k++)
        begin
            v = res[k];
            if (v < 0)
                v = 0;
            if (v > 16384)
                v = 16384;
            res[k] = (v * 255) / 16384;
        end
        o.chan0_out  = res[0][7:0];
        o.chan1_out  = res[1][7:0];
        o.chan2_out  = res[2][7:0];
        o.frame_last = p.end_of_frame;
        return o;
    endfunction

    function automatic yiqpo_pkg::pix_in_t mk_pix(int c0, int c1, int c2, int py,
                                                  int pi_, int pq, int eof);
        yiqpo_pkg::pix_in_t p;
        p.chan0_in     = c0[7:0];
        p.chan1_in     = c1[7:0];
        p.chan2_in     = c2[7:0];
        p.pulse_y      = py[15:0];
        p.pulse_i      = pi_[15:0];
        p.pulse_q      = pq[15:0];
        p.end_of_frame = eof[0];
        return p;
    endfunction

    function automatic yiqpo_pkg::pix_out_t mk_out(int c0, int c1, int c2, int eof);
        yiqpo_pkg::pix_out_t o;
        o.chan0_out  = c0[7:0];
        o.chan1_out  = c1[7:0];
        o.chan2_out  = c2[7:0];
        o.frame_last = eof[0];
        return o;
    endfunction

    function automatic yiqpo_pkg::pix_in_t rand_pixel();
        yiqpo_pkg::pix_in_t p;
        int      mode;
        p.chan0_in = 8'($urandom);
        p.chan1_in = 8'($urandom);
        p.chan2_in = 8'($urandom);
        p.pulse_y  = 16'($urandom);
        p.pulse_i  = 16'($urandom);
        p.pulse_q  = 16'($urandom);
        mode = $urandom_range(0, 3);
        // mostly modest pulses so outputs stay off the rails
        if (mode != 0)
        begin
            p.pulse_y = 16'($signed($urandom_range(0, 4096)) - 2048);
            p.pulse_i = 16'($signed($urandom_range(0, 4096)) - 2048);
            p.pulse_q = 16'($signed($urandom_range(0, 4096)) - 2048);
        end
        p.end_of_frame = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout at %0t", $time);
                $display("** yiq_pulse_overlay_pixel: FAILED **");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        dst_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                dst_stall <= 1'b1;
            else
                dst_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // result check at the rising edge
    initial
    begin
        yiqpo_pkg::pix_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && dst_valid && !dst_stall)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $display("%0t: unexpected transaction %h", $time, dst_data);
                    error_count++;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    checked_count++;
                    if (dst_data.chan0_out !== want.chan0_out)
                    begin
                        $display("%0t: chan0 expected %0d actual %0d", $time,
                                 want.chan0_out, dst_data.chan0_out);
                        error_count++;
                    end
                    if (dst_data.chan1_out !== want.chan1_out)
                    begin
                        $display("%0t: chan1 expected %0d actual %0d", $time,
                                 want.chan1_out, dst_data.chan1_out);
                        error_count++;
                    end
                    if (dst_data.chan2_out !== want.chan2_out)
                    begin
                        $display("%0t: chan2 expected %0d actual %0d", $time,
                                 want.chan2_out, dst_data.chan2_out);
                        error_count++;
                    end
                    if (dst_data.frame_last !== want.frame_last)
                    begin
                        $display("%0t: frame_last expected %0b actual %0b", $time,
                                 want.frame_last, dst_data.frame_last);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic send_pixel(yiqpo_pkg::pix_in_t p, logic known, yiqpo_pkg::pix_out_t want);
        yiqpo_pkg::pix_out_t model;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= p;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        model = overlay_pixel(p);
        if (known && model !== want)
        begin
            $display("%0t: table row mismatch expected %h actual %h", $time, want, model);
            error_count++;
        end
        pixel_queue.insert(pixel_queue.size(), known ? want : model);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        src_valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n)
            send_pixel(rand_pixel(), 1'b0, '0);
    endtask

    stim_row_t dir_tbl[$];

    task automatic add_row(yiqpo_pkg::pix_in_t p, logic known, yiqpo_pkg::pix_out_t want);
        stim_row_t row;
        row.pix   = p;
        row.known = known;
        row.want  = want;
        dir_tbl.insert(dir_tbl.size(), row);
    endtask

    initial
    begin
        error_count    = 0;
        checked_count  = 0;
        sent_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        rst_n          = 1'b0;
        src_valid      = 1'b0;
        src_data       = '0;

        // extremes typed in; the rest predicted
        add_row(mk_pix(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0));
        add_row(mk_pix(255, 255, 255, 0, 0, 0, 1), 1'b1, mk_out(255, 255, 255, 1));
        add_row(mk_pix(0, 0, 0, -32768, -32768, -32768, 0), 1'b1, mk_out(0, 0, 0, 0));
        add_row(mk_pix(0, 0, 0, 32767, 0, 0, 1), 1'b1, mk_out(255, 255, 255, 1));
        add_row(mk_pix(255, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_pix(0, 255, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_pix(0, 0, 255, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_pix(128, 128, 128, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_pix(100, 50, 200, 32767, 32767, 32767, 0), 1'b0, '0);
        add_row(mk_pix(100, 50, 200, 0, 32767, 0, 0), 1'b0, '0);
        add_row(mk_pix(100, 50, 200, 0, 0, 32767, 0), 1'b0, '0);
        add_row(mk_pix(100, 50, 200, 0, -32768, 0, 0), 1'b0, '0);
        add_row(mk_pix(100, 50, 200, 0, 0, -32768, 1), 1'b0, '0);
        add_row(mk_pix(200, 200, 10, 2000, 1500, -900, 0), 1'b0, '0);
        add_row(mk_pix(250, 10, 10, 0, 3000, 0, 0), 1'b0, '0);
        add_row(mk_pix(10, 250, 10, 0, -3000, -3000, 0), 1'b0, '0);
        add_row(mk_pix(1, 254, 127, -1, 1, -1, 0), 1'b0, '0);
        add_row(mk_pix(255, 255, 255, 4096, 0, 0, 1), 1'b0, '0);

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tbl[i])
            send_pixel(dir_tbl[i].pix, dir_tbl[i].known, dir_tbl[i].want);
        drain_results();

        random_phase(200, 0, 0);
        random_phase(150, 60, 0);
        random_phase(150, 0, 60);
        random_phase(150, 19, 19);

        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                hold_off = 1'b1;
                repeat (80)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(60, 0, 0);
        join
        drain_results();
        random_phase(40, 19, 19);
        drain_results();

        repeat (LATENCY + 10)
            @(negedge clk);
        $display("sent %0d pixels, checked %0d results over idle, stall and backpressure phases",
                 sent_count, checked_count);
        if (error_count == 0 && pixel_queue.size() == 0)
            $display("** yiq_pulse_overlay_pixel: PASSED **");
        else
            $display("** yiq_pulse_overlay_pixel: FAILED **");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/yiqpo_pkg.sv
src/yiq_pulse_overlay_pixel.sv
verif/yiq_pulse_overlay_pixel_tb.sv
